// File: sv/ptmr_pkg.sv
package ptmr_pkg;

	localparam int COUNT_W = 16;
	localparam int MODE_W = 12;
	localparam int TICK_W = 8;
	localparam int DATA_W = 16;
	localparam int CNT_OUT_W = 16;
	localparam int SHIFT_W = 4;
	localparam int ACC_W = 8;
	localparam int ACC_SUM_W = ACC_W + 1;
	localparam int SUM_W = ((COUNT_W > ACC_SUM_W) ? COUNT_W : ACC_SUM_W) + 1;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_WRITE_MODE,
		OP_WRITE_COUNT,
		OP_READ_STATUS
	} opcode_t;

	localparam logic [1:0] CLKS_DIV1 = 2'd0;
	localparam logic [1:0] CLKS_DIV16 = 2'd1;
	localparam logic [1:0] CLKS_DIV256 = 2'd2;
	localparam logic [1:0] CLKS_HBLANK = 2'd3;

	localparam logic [SHIFT_W-1:0] SHIFT_1 = 4'd0;
	localparam logic [SHIFT_W-1:0] SHIFT_16 = 4'd4;
	localparam logic [SHIFT_W-1:0] SHIFT_256 = 4'd8;

	localparam logic [MODE_W-1:0] FLAG_BITS = 12'hC00;
	localparam int CUE_BIT = 7;
	localparam int GATS_BIT = 3;

	typedef struct packed {
		opcode_t opcode;
		logic from_core;
		logic [TICK_W-1:0] ticks;
		logic [DATA_W-1:0] write_data;
	} req_t;

	typedef struct packed {
		logic [CNT_OUT_W-1:0] count_value;
		logic [MODE_W-1:0] mode_value;
		logic overflowed;
		logic hblank_source;
		logic gate_hblank_special;
	} rsp_t;

endpackage

// File: sv/ptmr_in_stage.sv
module ptmr_in_stage (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  ptmr_pkg::req_t req,
	input  logic advance,
	output logic valid_s1,
	output ptmr_pkg::req_t item_s1
);
	import ptmr_pkg::*;

	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
	end

endmodule

// File: sv/ptmr_state.sv
module ptmr_state (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  ptmr_pkg::req_t item_s1,
	output ptmr_pkg::rsp_t result
);
	import ptmr_pkg::*;

	logic [COUNT_W-1:0] count_q, count_d;
	logic [MODE_W-1:0] mode_q, mode_d;
	logic [SHIFT_W-1:0] shift_q, shift_d;
	logic [ACC_W-1:0] accum_q, accum_d;
	logic flag_q, flag_d;

	logic [ACC_SUM_W-1:0] acc_sum;
	logic [ACC_SUM_W-1:0] steps;
	logic [ACC_W-1:0] rem_mask;
	logic [SUM_W-1:0] count_sum;
	logic [MODE_W-1:0] wr_val;
	logic [MODE_W-1:0] mode_wr;

	always_comb begin
		acc_sum = {1'b0, accum_q} + {1'b0, item_s1.ticks};
		steps = acc_sum >> shift_q;
		rem_mask = ACC_W'((ACC_SUM_W'(1) << shift_q) - ACC_SUM_W'(1));
		count_sum = SUM_W'(count_q) + SUM_W'(steps);
		wr_val = item_s1.write_data[MODE_W-1:0];
		if (item_s1.from_core) begin
			mode_wr = (wr_val & ~FLAG_BITS) | (mode_q & FLAG_BITS & ~wr_val);
		end else begin
			mode_wr = wr_val;
		end
	end

	always_comb begin
		count_d = count_q;
		mode_d = mode_q;
		shift_d = shift_q;
		accum_d = accum_q;
		flag_d = flag_q;
		case (item_s1.opcode)
			OP_TICK: begin
				accum_d = ACC_W'(acc_sum) & rem_mask;
				count_d = count_sum[COUNT_W-1:0];
				if (|count_sum[SUM_W-1:COUNT_W]) begin
					flag_d = 1'b1;
				end
			end
			OP_WRITE_MODE: begin
				mode_d = mode_wr;
				if (item_s1.from_core && mode_wr[CUE_BIT]) begin
					count_d = '0;
				end
				case (mode_wr[1:0])
					CLKS_DIV1: begin
						shift_d = SHIFT_1;
						accum_d = '0;
					end
					CLKS_DIV16: begin
						shift_d = SHIFT_16;
						accum_d = '0;
					end
					CLKS_DIV256: begin
						shift_d = SHIFT_256;
						accum_d = '0;
					end
					default: begin
						shift_d = shift_q;
					end
				endcase
			end
			OP_WRITE_COUNT: begin
				count_d = COUNT_W'(item_s1.write_data);
			end
			OP_READ_STATUS: begin
				flag_d = 1'b0;
			end
			default: begin
				flag_d = flag_q;
			end
		endcase
	end

	always_comb begin
		result.count_value = CNT_OUT_W'(count_d);
		result.mode_value = mode_d;
		result.overflowed = (item_s1.opcode == OP_READ_STATUS) ? flag_q : flag_d;
		result.hblank_source = (mode_d[1:0] == CLKS_HBLANK);
		result.gate_hblank_special = (mode_d[1:0] == CLKS_HBLANK) && !mode_d[GATS_BIT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mode_q <= '0;
			shift_q <= SHIFT_1;
			accum_q <= '0;
			flag_q <= 1'b0;
		end else if (advance) begin
			count_q <= count_d;
			mode_q <= mode_d;
			shift_q <= shift_d;
			accum_q <= accum_d;
			flag_q <= flag_d;
		end
	end

endmodule

// File: sv/ptmr_out_stage.sv
module ptmr_out_stage (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  ptmr_pkg::rsp_t result,
	output logic out_free,
	output logic rsp_valid,
	input  logic rsp_ready,
	output ptmr_pkg::rsp_t rsp
);
	import ptmr_pkg::*;

	assign out_free = !rsp_valid || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (advance) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp <= result;
		end
	end

endmodule

// File: sv/prescaled_timer_with_mode_register_core.sv
// An accepted request goes through the input register and then the output register, which holds its response.
// Throughput is one transaction per cycle while the response side keeps taking results.
// The timer state is computed from the input register and loaded on advance, so no item waits on another.
// Reset clears the count, mode, prescaler, accumulator and overflow flag, and empties both stages.
module prescaled_timer_with_mode_register_core (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  ptmr_pkg::req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output ptmr_pkg::rsp_t rsp
);
	import ptmr_pkg::*;

	logic valid_s1;
	req_t item_s1;
	rsp_t result;
	logic out_free;
	logic advance;

	assign advance = valid_s1 && out_free;

	ptmr_in_stage u_in_stage (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.advance(advance),
		.valid_s1(valid_s1),
		.item_s1(item_s1)
	);

	ptmr_state u_state (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.item_s1(item_s1),
		.result(result)
	);

	ptmr_out_stage u_out_stage (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.result(result),
		.out_free(out_free),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> valid_s1)
		else $error("Accepted request did not reach the input register.");

	a_advance_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid)
		else $error("Advanced item produced no response.");

	a_gate_implies_hblank: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!rsp.gate_hblank_special || rsp.hblank_source))
		else $error("Gate special flag set without hblank clock select.");

	a_raw_mode_write: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.opcode == OP_WRITE_MODE && !item_s1.from_core
		|=> rsp.mode_value == $past(item_s1.write_data[MODE_W-1:0]))
		else $error("Raw mode write did not load the mode register.");
`endif

endmodule

// File: tb/tb_prescaled_timer_with_mode_register_core.sv
module tb_prescaled_timer_with_mode_register_core;

	import ptmr_pkg::*;

	localparam int N_DIR = 26;
	localparam int N_RAND = 700;
	localparam int CYCLE_LIMIT = 200000;
	localparam int STALL_AT = 150;
	localparam int STALL_LEN = 60;

	typedef struct packed {
		req_t rq;
		logic typed;
		rsp_t rs;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	logic [COUNT_W-1:0] m_count;
	logic [MODE_W-1:0] m_mode;
	logic [SHIFT_W-1:0] m_shift;
	logic [ACC_SUM_W-1:0] m_accum;
	logic m_ovf;

	rsp_t pending_rsp[$];
	rsp_t want_rsp;
	int errors = 0;
	int cycles = 0;
	int n_sent = 0;
	int stall_left = 0;
	bit stall_done = 1'b0;
	bit quiet = 1'b0;

	dir_row_t dir_tab [0:N_DIR-1] = '{
		'{'{OP_READ_STATUS, 1'b0, 8'h00, 16'h0000}, 1'b1, '{16'h0000, 12'h000, 1'b0, 1'b0, 1'b0}},
		'{'{OP_WRITE_COUNT, 1'b0, 8'h00, 16'hFFFF}, 1'b1, '{16'hFFFF, 12'h000, 1'b0, 1'b0, 1'b0}},
		'{'{OP_TICK, 1'b0, 8'h01, 16'h0000}, 1'b1, '{16'h0000, 12'h000, 1'b1, 1'b0, 1'b0}},
		'{'{OP_READ_STATUS, 1'b1, 8'hFF, 16'hFFFF}, 1'b1, '{16'h0000, 12'h000, 1'b1, 1'b0, 1'b0}},
		'{'{OP_READ_STATUS, 1'b0, 8'h00, 16'h0000}, 1'b1, '{16'h0000, 12'h000, 1'b0, 1'b0, 1'b0}},
		'{'{OP_TICK, 1'b1, 8'hFF, 16'hFFFF}, 1'b1, '{16'h00FF, 12'h000, 1'b0, 1'b0, 1'b0}},
		'{'{OP_WRITE_MODE, 1'b0, 8'h00, 16'hFFFF}, 1'b1, '{16'h00FF, 12'hFFF, 1'b0, 1'b1, 1'b0}},
		'{'{OP_WRITE_MODE, 1'b1, 8'h00, 16'h0000}, 1'b1, '{16'h00FF, 12'hC00, 1'b0, 1'b0, 1'b0}},
		'{'{OP_WRITE_MODE, 1'b1, 8'h00, 16'h0C00}, 1'b1, '{16'h00FF, 12'h000, 1'b0, 1'b0, 1'b0}},
		'{'{OP_WRITE_MODE, 1'b1, 8'hFF, 16'hF003}, 1'b0, '0},
		'{'{OP_WRITE_MODE, 1'b0, 8'h00, 16'h0001}, 1'b0, '0},
		'{'{OP_TICK, 1'b0, 8'h0F, 16'h0000}, 1'b0, '0},
		'{'{OP_TICK, 1'b0, 8'hFF, 16'h0000}, 1'b0, '0},
		'{'{OP_WRITE_MODE, 1'b0, 8'h00, 16'h0002}, 1'b0, '0},
		'{'{OP_TICK, 1'b0, 8'hFF, 16'h0000}, 1'b0, '0},
		'{'{OP_TICK, 1'b0, 8'hFF, 16'h0000}, 1'b0, '0},
		'{'{OP_TICK, 1'b0, 8'h02, 16'h0000}, 1'b0, '0},
		'{'{OP_WRITE_MODE, 1'b1, 8'h00, 16'h0082}, 1'b0, '0},
		'{'{OP_WRITE_COUNT, 1'b1, 8'hFF, 16'hABCD}, 1'b0, '0},
		'{'{OP_WRITE_MODE, 1'b0, 8'h00, 16'h008B}, 1'b0, '0},
		'{'{OP_WRITE_COUNT, 1'b0, 8'h00, 16'hFFF0}, 1'b0, '0},
		'{'{OP_WRITE_MODE, 1'b0, 8'h00, 16'h0000}, 1'b0, '0},
		'{'{OP_TICK, 1'b0, 8'hFF, 16'h0000}, 1'b0, '0},
		'{'{OP_WRITE_MODE, 1'b0, 8'h00, 16'h0C00}, 1'b0, '0},
		'{'{OP_WRITE_MODE, 1'b1, 8'h00, 16'h0400}, 1'b0, '0},
		'{'{OP_READ_STATUS, 1'b0, 8'h5A, 16'h1234}, 1'b0, '0}
	};

	prescaled_timer_with_mode_register_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #6 clk = ~clk;

	task automatic predict_timer(input req_t r, output rsp_t o);
		logic [ACC_SUM_W-1:0] acc;
		logic [ACC_SUM_W-1:0] steps;
		logic [COUNT_W:0] sum;
		logic [MODE_W-1:0] v;
		logic seen;
		case (r.opcode)
			OP_TICK: begin
				acc = m_accum + {1'b0, r.ticks};
				steps = acc >> m_shift;
				m_accum = acc & ((ACC_SUM_W'(1) << m_shift) - ACC_SUM_W'(1));
				sum = {1'b0, m_count} + (COUNT_W + 1)'(steps);
				if (sum[COUNT_W])
					m_ovf = 1'b1;
				m_count = sum[COUNT_W-1:0];
			end
			OP_WRITE_MODE: begin
				v = r.write_data[MODE_W-1:0];
				if (r.from_core) begin
					m_mode = (v & ~FLAG_BITS) | (m_mode & FLAG_BITS & ~v);
					if (m_mode[CUE_BIT])
						m_count = '0;
				end else begin
					m_mode = v;
				end
				case (m_mode[1:0])
					CLKS_DIV1: begin
						m_shift = SHIFT_1;
						m_accum = '0;
					end
					CLKS_DIV16: begin
						m_shift = SHIFT_16;
						m_accum = '0;
					end
					CLKS_DIV256: begin
						m_shift = SHIFT_256;
						m_accum = '0;
					end
					default: begin
					end
				endcase
			end
			OP_WRITE_COUNT: begin
				m_count = r.write_data;
			end
			default: begin
			end
		endcase
		seen = m_ovf;
		if (r.opcode == OP_READ_STATUS)
			m_ovf = 1'b0;
		o.count_value = m_count;
		o.mode_value = m_mode;
		o.overflowed = seen;
		o.hblank_source = (m_mode[1:0] == CLKS_HBLANK);
		o.gate_hblank_special = (m_mode[1:0] == CLKS_HBLANK) && !m_mode[GATS_BIT];
	endtask

	task automatic send_item(input req_t r, input logic typed, input rsp_t typed_rsp);
		rsp_t pred;
		if (!quiet && $urandom_range(99) < 7) begin
			req_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 30)
				@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predict_timer(r, pred);
		pending_rsp.push_back(typed ? typed_rsp : pred);
		n_sent++;
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
		end
	endtask

	function automatic req_t random_item();
		req_t r;
		int k;
		k = $urandom_range(99);
		r.from_core = 1'($urandom_range(1));
		r.ticks = 8'($urandom_range(255));
		r.write_data = 16'($urandom_range(16'hFFFF));
		if (k < 50) begin
			r.opcode = OP_TICK;
		end else if (k < 65) begin
			r.opcode = OP_WRITE_MODE;
			if ($urandom_range(3) != 0)
				r.write_data[CUE_BIT] = 1'b0;
		end else if (k < 78) begin
			r.opcode = OP_WRITE_COUNT;
			if ($urandom_range(1) == 0)
				r.write_data[15:8] = 8'hFF;
		end else begin
			r.opcode = OP_READ_STATUS;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_ready <= 1'b0;
		end else if (!stall_done && n_sent >= STALL_AT) begin
			stall_left <= STALL_LEN;
			stall_done <= 1'b1;
			rsp_ready <= 1'b0;
		end else if (quiet) begin
			rsp_ready <= 1'b1;
		end else begin
			rsp_ready <= ($urandom_range(99) >= 7);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				errors++;
				$display("%0t response with no expectation: expected none actual %h", $time, rsp);
			end else begin
				want_rsp = pending_rsp.pop_front();
				check_field("count_value", want_rsp.count_value, rsp.count_value);
				check_field("mode_value", 16'(want_rsp.mode_value), 16'(rsp.mode_value));
				check_field("overflowed", 16'(want_rsp.overflowed), 16'(rsp.overflowed));
				check_field("hblank_source", 16'(want_rsp.hblank_source),
					16'(rsp.hblank_source));
				check_field("gate_hblank_special", 16'(want_rsp.gate_hblank_special),
					16'(rsp.gate_hblank_special));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_prescaled_timer_with_mode_register_core NOT OK");
			$finish;
		end
	end

	initial begin
		m_count = '0;
		m_mode = '0;
		m_shift = SHIFT_1;
		m_accum = '0;
		m_ovf = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < N_DIR; i++)
			send_item(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].rs);
		for (int i = 0; i < N_RAND; i++) begin
			quiet = (i >= 250 && i < 400);
			send_item(random_item(), 1'b0, '0);
		end
		quiet = 1'b0;
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("tb_prescaled_timer_with_mode_register_core OK");
		else
			$display("tb_prescaled_timer_with_mode_register_core NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
sv/ptmr_pkg.sv
sv/ptmr_in_stage.sv
sv/ptmr_state.sv
sv/ptmr_out_stage.sv
sv/prescaled_timer_with_mode_register_core.sv
tb/tb_prescaled_timer_with_mode_register_core.sv
